>>> rtl/core/sbus_frame_receiver_macros.svh
// assertion macros for the s.bus frame receiver
// used by the rtl modules that carry concurrent checks; no other dependencies
`ifndef SBUS_FRAME_RECEIVER_MACROS_SVH
`define SBUS_FRAME_RECEIVER_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define SBUSR_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define SBUSR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sbusr_pkg.sv
// shared constants, types and helpers for the s.bus frame receiver
// no dependencies
package sbusr_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int CHANNEL_COUNT = 18;
    localparam int PROP_CHANNELS = 16;
    localparam int CHAN_BITS     = 11;
    // bytes 1..23 are kept: 22 bytes of channel data plus the flags byte
    localparam int KEEP_BYTES    = 23;
    localparam int KEEP_BITS     = KEEP_BYTES * 8;
    localparam int PROP_BITS     = PROP_CHANNELS * CHAN_BITS;
    localparam int PULSE_OFFSET  = 880;

    // register reset values
    localparam logic [7:0]  TIMEOUT_RESET     = 8'd3;
    localparam logic [7:0]  START_BYTE_RESET  = 8'd15;
    localparam logic [10:0] SWITCH_HIGH_RESET = 11'd1812;
    localparam logic [10:0] SWITCH_LOW_RESET  = 11'd172;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_TIMEOUT = 2'd0,
        CFG_START_BYTE    = 2'd1,
        CFG_SWITCH_HIGH   = 2'd2,
        CFG_SWITCH_LOW    = 2'd3
    } t_cfg_index;

    // decoded frame handed to the result sequencer
    typedef struct packed {
        logic [PROP_BITS-1:0] chan_bits;
        logic [1:0]           flags;
    } t_frame;

    // pulse width in microseconds: raw * 5 / 8 + 880, truncated
    function automatic logic [11:0] pulse_of(input logic [CHAN_BITS-1:0] raw);
        logic [13:0] times5;
        times5 = {3'b000, raw} + {1'b0, raw, 2'b00};
        return 12'(times5 >> 3) + 12'(PULSE_OFFSET);
    endfunction

endpackage

>>> rtl/core/sbusr_emitter.sv
// result sequencer: walks a completed frame and emits 18 channel words
// depends on sbusr_pkg and sbus_frame_receiver_macros.svh
`include "sbus_frame_receiver_macros.svh"

module sbusr_emitter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  sbusr_pkg::t_frame    i_frame,
    input  logic [10:0]          i_switch_high,
    input  logic [10:0]          i_switch_low,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [4:0]           o_channel_index,
    output logic [10:0]          o_raw_value,
    output logic [11:0]          o_pulse_us,
    output logic                 o_last_of_frame
);

    localparam logic [4:0] LAST_CH  = 5'(sbusr_pkg::CHANNEL_COUNT - 1);
    localparam logic [4:0] FLAG0_CH = 5'(sbusr_pkg::PROP_CHANNELS);

    logic                 r_busy;
    logic [4:0]           r_ch;
    sbusr_pkg::t_frame    r_frame;
    logic                 w_flag;
    logic [10:0]          w_raw;

    // sequencer: load a frame, then step one channel per taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ch   <= '0;
        end else if (i_load) begin
            r_busy  <= 1'b1;
            r_ch    <= '0;
            r_frame <= i_frame;
        end else if (r_busy && i_ready) begin
            if (r_ch == LAST_CH) begin
                r_busy <= 1'b0;
            end else begin
                r_ch              <= r_ch + 5'd1;
                r_frame.chan_bits <= r_frame.chan_bits >> sbusr_pkg::CHAN_BITS;
            end
        end
    end

    // digital channels map their flag bit to the configured levels
    assign w_flag = (r_ch == FLAG0_CH) ? r_frame.flags[0] : r_frame.flags[1];
    assign w_raw  = (r_ch < FLAG0_CH) ? r_frame.chan_bits[sbusr_pkg::CHAN_BITS-1:0]
                                      : (w_flag ? i_switch_high : i_switch_low);

    assign o_valid         = r_busy;
    assign o_channel_index = r_ch;
    assign o_raw_value     = w_raw;
    assign o_pulse_us      = sbusr_pkg::pulse_of(w_raw);
    assign o_last_of_frame = (r_ch == LAST_CH);

    `SBUSR_ASSERT_NOW(a_load_idle, i_clk, i_rst_n, i_load, !r_busy, "frame loaded while busy")
    `SBUSR_ASSERT_NEXT(a_run_holds, i_clk, i_rst_n, r_busy && i_ready && r_ch != LAST_CH, r_busy, "sequence ended early")
    `SBUSR_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, r_busy && i_ready && r_ch == LAST_CH, !r_busy, "sequence ran past last channel")
    `SBUSR_ASSERT_NOW(a_ch_range, i_clk, i_rst_n, r_busy, r_ch <= LAST_CH, "channel counter out of range")

endmodule

>>> rtl/core/sbus_frame_receiver.sv
// s.bus frame receiver top level: frame assembly, timeout and configuration
// depends on sbusr_pkg and sbusr_emitter
//
// channel   handshake          payload
// rx in     i_valid / o_ready  i_rx_byte, i_arrival_ms
// result    o_valid / i_ready  o_channel_index, o_raw_value, o_pulse_us, o_last_of_frame
// config    i_cfg_we           i_cfg_index, i_cfg_data
//
// a byte is taken while o_ready is high; the byte that completes a frame loads the
// result sequencer, which gives 18 words, one per cycle when not stalled.
// while those words are pending, a byte arriving at position 24 waits, since
// the sequencer holds one frame; other bytes are taken every cycle.
// reset is synchronous, clears position and frame start time and sets the config registers to their reset values.

module sbus_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_arrival_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_channel_index,
    output logic [10:0] o_raw_value,
    output logic [11:0] o_pulse_us,
    output logic        o_last_of_frame,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam logic [4:0] FULL_POS = 5'(sbusr_pkg::FRAME_BYTES);
    localparam logic [4:0] LAST_POS = 5'(sbusr_pkg::FRAME_BYTES - 1);
    localparam logic [4:0] KEEP_END = 5'(sbusr_pkg::KEEP_BYTES);

    logic [7:0]                     r_timeout;
    logic [7:0]                     r_start_byte;
    logic [10:0]                    r_switch_high;
    logic [10:0]                    r_switch_low;
    logic [4:0]                     r_pos;
    logic [4:0]                     n_pos;
    logic [31:0]                    r_start_time;
    logic [31:0]                    n_start_time;
    logic [sbusr_pkg::KEEP_BITS-1:0] r_bytes;
    logic                           w_accept;
    logic [31:0]                    w_elapsed;
    logic [4:0]                     w_pos_eff;
    logic                           w_shift;
    logic                           w_load;
    sbusr_pkg::t_frame              w_frame;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= sbusr_pkg::TIMEOUT_RESET;
            r_start_byte  <= sbusr_pkg::START_BYTE_RESET;
            r_switch_high <= sbusr_pkg::SWITCH_HIGH_RESET;
            r_switch_low  <= sbusr_pkg::SWITCH_LOW_RESET;
        end else if (i_cfg_we) begin
            case (sbusr_pkg::t_cfg_index'(i_cfg_index))
                sbusr_pkg::CFG_FRAME_TIMEOUT: r_timeout     <= i_cfg_data[7:0];
                sbusr_pkg::CFG_START_BYTE:    r_start_byte  <= i_cfg_data[7:0];
                sbusr_pkg::CFG_SWITCH_HIGH:   r_switch_high <= i_cfg_data;
                sbusr_pkg::CFG_SWITCH_LOW:    r_switch_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold the completing byte while the sequencer still owns a frame
    assign o_ready  = !(o_valid && r_pos == LAST_POS);
    assign w_accept = i_valid && o_ready;

    // timeout check and next position
    assign w_elapsed = i_arrival_ms - r_start_time;
    assign w_pos_eff = (w_elapsed > {24'd0, r_timeout}) ? 5'd0 : r_pos;

    always_comb begin
        n_pos        = w_pos_eff;
        n_start_time = r_start_time;
        w_shift      = 1'b0;
        w_load       = 1'b0;
        if (w_pos_eff == 5'd0) begin
            if (i_rx_byte == r_start_byte) begin
                n_pos        = 5'd1;
                n_start_time = i_arrival_ms;
            end
        end else if (w_pos_eff < FULL_POS) begin
            n_pos   = w_pos_eff + 5'd1;
            w_shift = (w_pos_eff <= KEEP_END);
            w_load  = (w_pos_eff == LAST_POS);
        end
    end

    // frame position and start time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_start_time <= '0;
        end else if (w_accept) begin
            r_pos        <= n_pos;
            r_start_time <= n_start_time;
        end
    end

    // bytes 1..23 shift in from the top, byte 1 ends at the bottom
    always_ff @(posedge i_clk) begin
        if (w_accept && w_shift) begin
            r_bytes <= {i_rx_byte, r_bytes[sbusr_pkg::KEEP_BITS-1:8]};
        end
    end

    assign w_frame.chan_bits = r_bytes[sbusr_pkg::PROP_BITS-1:0];
    assign w_frame.flags     = r_bytes[sbusr_pkg::PROP_BITS+1:sbusr_pkg::PROP_BITS];

    // result sequencer
    sbusr_emitter u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_accept && w_load),
        .i_frame         (w_frame),
        .i_switch_high   (r_switch_high),
        .i_switch_low    (r_switch_low),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_channel_index (o_channel_index),
        .o_raw_value     (o_raw_value),
        .o_pulse_us      (o_pulse_us),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule
